// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Both macros sample on clk_i; ASSERT_CHK is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/necir_pkg.sv =====
`default_nettype none

package necir_pkg;

  localparam int unsigned TICK_W  = 15;
  localparam int unsigned SUM_W   = TICK_W + 1;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned REG_NUM = 8;
  localparam int unsigned REG_IDX_W = 3;

  // Acceptance half-width of every timing window, in ticks.
  localparam int unsigned TOLERANCE = 200;
  localparam logic [SUM_W-1:0] TOL_SUM = SUM_W'(TOLERANCE);

  localparam logic [COUNT_W-1:0] HALF_BITS            = COUNT_W'(16);
  localparam logic [COUNT_W-1:0] DATA_BITS            = COUNT_W'(32);
  localparam logic [COUNT_W-1:0] DATA_FRAME_SYMBOLS   = COUNT_W'(34);
  localparam logic [COUNT_W-1:0] REPEAT_FRAME_SYMBOLS = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX            = COUNT_W'(63);

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_REPEAT  = 2'd2
  } frame_kind_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_ZERO_MARK    = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_MARK     = 3'd4,
    REG_ONE_SPACE    = 3'd5,
    REG_REPEAT_MARK  = 3'd6,
    REG_REPEAT_SPACE = 3'd7
  } reg_idx_e;

  localparam logic [TICK_W-1:0] CFG_RESET [REG_NUM] = '{
    15'd9000, 15'd4500, 15'd560, 15'd560, 15'd560, 15'd1690, 15'd9000, 15'd2250
  };

  // True when value lies strictly inside nominal +/- TOLERANCE.
  function automatic logic in_window(logic [TICK_W-1:0] value, logic [TICK_W-1:0] nominal);
    logic [SUM_W-1:0] v_ext;
    logic [SUM_W-1:0] n_ext;
    v_ext = {1'b0, value};
    n_ext = {1'b0, nominal};
    return (v_ext < n_ext + TOL_SUM) && (v_ext + TOL_SUM > n_ext);
  endfunction

endpackage

`default_nettype wire

// ===== sv/nec_ir_frame_decoder_top.sv =====
// NEC infrared frame decoder. Each input transaction is one received pulse symbol
// (mark and space durations in ticks, plus a flag on the last symbol of the frame);
// a result transaction leaves only for a symbol with frame_end set, carrying the
// frame kind (0 invalid, 1 data, 2 repeat) and the 16-bit address and command,
// which are the last valid pair for a repeat and zero for an invalid frame.
// Durations are accepted strictly inside nominal +/- 200 ticks; nominals are
// programmed through the configuration port (index 0..7: leader mark/space, zero
// mark/space, one mark/space, repeat mark/space), by the user only while the block
// is idle; the block does not enforce this. One symbol is taken per clock unless a
// frame-ending symbol waits on an untaken result; it sits in the input register,
// where the window comparators and the frame state update run, and its result
// loads the output register as it advances. The output register decouples the
// two sides: symbols that end no frame flow on while a result waits to be taken.
`default_nettype none

`include "assert_macros.svh"

module nec_ir_frame_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [14:0] cfg_wdata_i,
  // symbol input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [14:0] mark_ticks_i,
  input  wire logic [14:0] space_ticks_i,
  input  wire logic        frame_end_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       frame_kind_o,
  output logic [15:0]      address_out_o,
  output logic [15:0]      command_out_o
);

  // Timing registers, each read at its own fixed place.
  logic [14:0] cfg_q [necir_pkg::REG_NUM];

  // Input register.
  logic        s1_valid_q;
  logic [14:0] s1_mark_q;
  logic [14:0] s1_space_q;
  logic        s1_end_q;

  // Frame state.
  logic [5:0]  count_q, count_d;
  logic        good_q, good_d;
  logic        first_rep_q, first_rep_d;
  logic [15:0] addr_sh_q, addr_sh_d;
  logic [15:0] cmd_sh_q, cmd_sh_d;
  logic [15:0] last_addr_q, last_addr_d;
  logic [15:0] last_cmd_q, last_cmd_d;

  // Result register.
  logic                   out_valid_q;
  necir_pkg::frame_kind_e out_kind_q, kind_d;
  logic [15:0]            out_addr_q, out_addr_d;
  logic [15:0]            out_cmd_q, out_cmd_d;

  logic s1_adv;
  logic leader_ok, repeat_ok, one_ok, zero_ok;
  logic is_leader_slot, is_bit_slot;
  logic [5:0] count_inc;
  logic [15:0] addr_upd, cmd_upd;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, write the indexed timing register.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= necir_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. A symbol in the input register advances unless it ends a frame
  // and the result register is still held by an untaken result.
  // ---------------------------------------------------------------------------
  assign s1_adv     = s1_valid_q && (!s1_end_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_mark_q  <= mark_ticks_i;
      s1_space_q <= space_ticks_i;
      s1_end_q   <= frame_end_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Symbol classification: four window pairs against the programmed nominals.
  // ---------------------------------------------------------------------------
  assign leader_ok =
    necir_pkg::in_window(s1_mark_q,  cfg_q[necir_pkg::REG_LEADER_MARK]) &&
    necir_pkg::in_window(s1_space_q, cfg_q[necir_pkg::REG_LEADER_SPACE]);
  assign repeat_ok =
    necir_pkg::in_window(s1_mark_q,  cfg_q[necir_pkg::REG_REPEAT_MARK]) &&
    necir_pkg::in_window(s1_space_q, cfg_q[necir_pkg::REG_REPEAT_SPACE]);
  assign one_ok =
    necir_pkg::in_window(s1_mark_q,  cfg_q[necir_pkg::REG_ONE_MARK]) &&
    necir_pkg::in_window(s1_space_q, cfg_q[necir_pkg::REG_ONE_SPACE]);
  assign zero_ok =
    necir_pkg::in_window(s1_mark_q,  cfg_q[necir_pkg::REG_ZERO_MARK]) &&
    necir_pkg::in_window(s1_space_q, cfg_q[necir_pkg::REG_ZERO_SPACE]);

  assign is_leader_slot = (count_q == '0);
  assign is_bit_slot    = !is_leader_slot && (count_q <= necir_pkg::DATA_BITS);

  // Saturate the symbol count; symbols past the stop symbol change nothing else.
  assign count_inc = (count_q < necir_pkg::COUNT_MAX) ? count_q + 6'd1 : necir_pkg::COUNT_MAX;

  // Shift in LSB first; a bit that matches both timings reads as a one.
  always_comb begin
    addr_upd = addr_sh_q;
    cmd_upd  = cmd_sh_q;
    if (is_bit_slot) begin
      if (count_q <= necir_pkg::HALF_BITS) begin
        addr_upd = {one_ok, addr_sh_q[15:1]};
      end else begin
        cmd_upd = {one_ok, cmd_sh_q[15:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state update and result formation.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic good_upd;
    logic rep_upd;
    good_upd = good_q;
    if (is_leader_slot && !leader_ok) begin
      good_upd = 1'b0;
    end
    if (is_bit_slot && !one_ok && !zero_ok) begin
      good_upd = 1'b0;
    end
    rep_upd = is_leader_slot ? repeat_ok : first_rep_q;

    count_d     = count_q;
    good_d      = good_q;
    first_rep_d = first_rep_q;
    addr_sh_d   = addr_sh_q;
    cmd_sh_d    = cmd_sh_q;
    last_addr_d = last_addr_q;
    last_cmd_d  = last_cmd_q;
    kind_d      = necir_pkg::KIND_INVALID;
    out_addr_d  = '0;
    out_cmd_d   = '0;

    if (s1_adv) begin
      if (s1_end_q) begin
        if (count_inc == necir_pkg::DATA_FRAME_SYMBOLS && good_upd) begin
          kind_d      = necir_pkg::KIND_DATA;
          last_addr_d = addr_upd;
          last_cmd_d  = cmd_upd;
          out_addr_d  = addr_upd;
          out_cmd_d   = cmd_upd;
        end else if (count_inc == necir_pkg::REPEAT_FRAME_SYMBOLS && rep_upd) begin
          kind_d     = necir_pkg::KIND_REPEAT;
          out_addr_d = last_addr_q;
          out_cmd_d  = last_cmd_q;
        end
        // drop the frame state, keep the last valid pair
        count_d     = '0;
        good_d      = 1'b1;
        first_rep_d = 1'b0;
        addr_sh_d   = '0;
        cmd_sh_d    = '0;
      end else begin
        count_d     = count_inc;
        good_d      = good_upd;
        first_rep_d = rep_upd;
        addr_sh_d   = addr_upd;
        cmd_sh_d    = cmd_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      good_q      <= 1'b1;
      first_rep_q <= 1'b0;
      addr_sh_q   <= '0;
      cmd_sh_q    <= '0;
      last_addr_q <= '0;
      last_cmd_q  <= '0;
    end else begin
      count_q     <= count_d;
      good_q      <= good_d;
      first_rep_q <= first_rep_d;
      addr_sh_q   <= addr_sh_d;
      cmd_sh_q    <= cmd_sh_d;
      last_addr_q <= last_addr_d;
      last_cmd_q  <= last_cmd_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on a frame-ending symbol, hold until taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (s1_adv && s1_end_q) || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_end_q) begin
      out_kind_q <= kind_d;
      out_addr_q <= out_addr_d;
      out_cmd_q  <= out_cmd_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_kind_o  = 2'(out_kind_q);
  assign address_out_o = out_addr_q;
  assign command_out_o = out_cmd_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_CHK(a_frame_restart, s1_adv && s1_end_q |=> count_q == '0 && good_q)
  `ASSERT_CHK(a_invalid_zero,
    out_valid_q && out_kind_q == necir_pkg::KIND_INVALID |-> out_addr_q == '0 && out_cmd_q == '0)
  `ASSERT_CHK(a_valid_uses_last,
    out_valid_q && out_kind_q != necir_pkg::KIND_INVALID |->
      out_addr_q == last_addr_q && out_cmd_q == last_cmd_q)
  `ASSERT_CHK(a_stall_holds, s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_mark_q))
  `ASSERT_ALWAYS(a_count_in_reset, !rst_ni |=> count_q == '0 && !out_valid_q)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TICK_W = necir_pkg::TICK_W;

  // Cycles to let pass once no result is outstanding before the config port is touched:
  // a symbol that ends no frame may still sit in the input register.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam int unsigned PHASE_SYMBOLS = 75;
  localparam int          NO_FAULT      = -1;
  localparam logic [TICK_W-1:0] TICK_TOP = '1;

  typedef enum logic [1:0] {
    STIM_SYMBOL,
    STIM_WRITE,
    STIM_HOLD
  } stim_kind_e;

  // One entry of the transmit plan: a symbol, a register write, or a pause until idle.
  typedef struct {
    stim_kind_e          kind;
    logic [TICK_W-1:0]   mark;
    logic [TICK_W-1:0]   space;
    logic                last;
    necir_pkg::reg_idx_e reg_idx;
    logic [TICK_W-1:0]   wdata;
    int unsigned         idle_pct;
    int unsigned         stall_pct;
  } stim_t;

  typedef struct {
    necir_pkg::frame_kind_e kind;
    logic [15:0]            address;
    logic [15:0]            command;
  } frame_report_t;

  // Clock, reset and every block input start at a known value.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i   = '0;
  logic [TICK_W-1:0] cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [TICK_W-1:0] mark_ticks_i  = '0;
  logic [TICK_W-1:0] space_ticks_i = '0;
  logic              frame_end_i   = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [1:0]        frame_kind_o;
  logic [15:0]       address_out_o;
  logic [15:0]       command_out_o;

  // Transmit plan, filled once by the stimulus block and drained by the driver.
  stim_t             tx_plan [$];
  logic [TICK_W-1:0] planned_nom [necir_pkg::REG_NUM];
  int unsigned       symbols_planned = 0;
  int unsigned       cur_idle_pct    = 0;
  int unsigned       cur_stall_pct   = 0;

  // Driver and sink pacing.
  int unsigned       gap_left   = 0;
  int unsigned       settle_cnt = 0;
  int unsigned       stall_left = 0;
  int unsigned       stall_pct  = 0;

  // Decoder shadow: programmed nominals and the state of the frame under way.
  logic [TICK_W-1:0] nominal [necir_pkg::REG_NUM];
  logic [5:0]        sym_count;
  logic              frame_ok;
  logic              opened_as_repeat;
  logic [15:0]       addr_sr;
  logic [15:0]       cmd_sr;
  logic [15:0]       held_addr;
  logic [15:0]       held_cmd;
  frame_report_t     frames_due [$];

  int unsigned       err_count = 0;

  nec_ir_frame_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mark_ticks_i (mark_ticks_i),
    .space_ticks_i(space_ticks_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_kind_o (frame_kind_o),
    .address_out_o(address_out_o),
    .command_out_o(command_out_o)
  );

  always #6 clk_i = ~clk_i;

  // Hold reset low from the start, then release it for good.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Generous ceiling: the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Decoder shadow
  // ---------------------------------------------------------------------------

  // Strictly inside nominal +/- tolerance; the lower bound may fall below zero.
  function automatic logic window_hit(input logic [TICK_W-1:0] value,
                                      input logic [TICK_W-1:0] nom);
    int v;
    int n;
    v = int'(value);
    n = int'(nom);
    return (v < n + int'(necir_pkg::TOLERANCE)) && (v + int'(necir_pkg::TOLERANCE) > n);
  endfunction

  function automatic logic pair_hit(input logic [TICK_W-1:0] mark,
                                    input logic [TICK_W-1:0] space,
                                    input necir_pkg::reg_idx_e mark_reg,
                                    input necir_pkg::reg_idx_e space_reg);
    return window_hit(mark, nominal[mark_reg]) && window_hit(space, nominal[space_reg]);
  endfunction

  task automatic clear_frame_state();
    sym_count        = '0;
    frame_ok         = 1'b1;
    opened_as_repeat = 1'b0;
    addr_sr          = '0;
    cmd_sr           = '0;
  endtask

  // Advance the frame state by one accepted symbol; queue the report when it ends a frame.
  task automatic decode_symbol(input logic [TICK_W-1:0] mark, input logic [TICK_W-1:0] space,
                               input logic last);
    logic          bit_val;
    frame_report_t rep;
    if (sym_count == '0) begin
      if (!pair_hit(mark, space, necir_pkg::REG_LEADER_MARK, necir_pkg::REG_LEADER_SPACE))
        frame_ok = 1'b0;
      opened_as_repeat = pair_hit(mark, space, necir_pkg::REG_REPEAT_MARK,
                                  necir_pkg::REG_REPEAT_SPACE);
    end else if (sym_count <= necir_pkg::DATA_BITS) begin
      // A symbol that fits both windows reads as a one.
      bit_val = 1'b0;
      if (pair_hit(mark, space, necir_pkg::REG_ONE_MARK, necir_pkg::REG_ONE_SPACE)) begin
        bit_val = 1'b1;
      end else if (!pair_hit(mark, space, necir_pkg::REG_ZERO_MARK,
                             necir_pkg::REG_ZERO_SPACE)) begin
        frame_ok = 1'b0;
      end
      if (sym_count <= necir_pkg::HALF_BITS) addr_sr = {bit_val, addr_sr[15:1]};
      else                                   cmd_sr  = {bit_val, cmd_sr[15:1]};
    end
    if (sym_count != necir_pkg::COUNT_MAX) sym_count = sym_count + 1'b1;
    if (last) begin
      rep.kind    = necir_pkg::KIND_INVALID;
      rep.address = '0;
      rep.command = '0;
      if (sym_count == necir_pkg::DATA_FRAME_SYMBOLS && frame_ok) begin
        held_addr   = addr_sr;
        held_cmd    = cmd_sr;
        rep.kind    = necir_pkg::KIND_DATA;
        rep.address = held_addr;
        rep.command = held_cmd;
      end else if (sym_count == necir_pkg::REPEAT_FRAME_SYMBOLS && opened_as_repeat) begin
        rep.kind    = necir_pkg::KIND_REPEAT;
        rep.address = held_addr;
        rep.command = held_cmd;
      end
      frames_due.push_back(rep);
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feeds the plan into the symbol and config channels.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t nxt;
    logic  sym_done;
    logic  wr_done;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_left    <= 0;
      settle_cnt  <= 0;
      for (int i = 0; i < necir_pkg::REG_NUM; i++) nominal[i] = necir_pkg::CFG_RESET[i];
      clear_frame_state();
      held_addr = '0;
      held_cmd  = '0;
    end else begin
      sym_done = in_valid_i && in_ready_o;
      wr_done  = cfg_valid_i && cfg_ready_o;
      if (sym_done) decode_symbol(mark_ticks_i, space_ticks_i, frame_end_i);
      if (wr_done)  nominal[cfg_index_i] = cfg_wdata_i;

      if ((in_valid_i && !sym_done) || (cfg_valid_i && !wr_done)) begin
        // hold the transaction until the block takes it
      end else if (gap_left != 0) begin
        in_valid_i  <= 1'b0;
        cfg_valid_i <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (tx_plan.size() == 0) begin
        in_valid_i  <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else begin
        nxt = tx_plan[0];
        stall_pct <= nxt.stall_pct;
        case (nxt.kind)
          STIM_HOLD: begin
            // Drop both valids until every report is in and the pipe has emptied.
            in_valid_i  <= 1'b0;
            cfg_valid_i <= 1'b0;
            if (frames_due.size() != 0) begin
              settle_cnt <= 0;
            end else if (settle_cnt >= SETTLE_CYCLES) begin
              void'(tx_plan.pop_front());
              settle_cnt <= 0;
            end else begin
              settle_cnt <= settle_cnt + 1;
            end
          end
          STIM_WRITE: begin
            in_valid_i  <= 1'b0;
            cfg_valid_i <= 1'b1;
            cfg_index_i <= nxt.reg_idx;
            cfg_wdata_i <= nxt.wdata;
            gap_left    <= ($urandom_range(0, 99) < nxt.idle_pct) ? $urandom_range(1, 3) : 0;
            void'(tx_plan.pop_front());
          end
          default: begin
            cfg_valid_i   <= 1'b0;
            in_valid_i    <= 1'b1;
            mark_ticks_i  <= nxt.mark;
            space_ticks_i <= nxt.space;
            frame_end_i   <= nxt.last;
            gap_left      <= ($urandom_range(0, 99) < nxt.idle_pct) ? $urandom_range(1, 3) : 0;
            void'(tx_plan.pop_front());
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest report due and
  // throttles out_ready_i in short bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    frame_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (frames_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d addr %h cmd %h",
                                    frame_kind_o, address_out_o, command_out_o));
        end else begin
          want = frames_due.pop_front();
          if (frame_kind_o !== want.kind)
            report_mismatch($sformatf("frame_kind got %0d want %0d", frame_kind_o, want.kind));
          if (address_out_o !== want.address)
            report_mismatch($sformatf("address got %h want %h", address_out_o, want.address));
          if (command_out_o !== want.command)
            report_mismatch($sformatf("command got %h want %h", command_out_o, want.command));
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Plan builders
  // ---------------------------------------------------------------------------
  task automatic push_symbol(input logic [TICK_W-1:0] mark, input logic [TICK_W-1:0] space,
                             input logic last);
    stim_t s;
    s.kind      = STIM_SYMBOL;
    s.mark      = mark;
    s.space     = space;
    s.last      = last;
    s.reg_idx   = necir_pkg::REG_LEADER_MARK;
    s.wdata     = '0;
    s.idle_pct  = cur_idle_pct;
    s.stall_pct = cur_stall_pct;
    tx_plan.push_back(s);
    symbols_planned++;
  endtask

  task automatic push_write(input necir_pkg::reg_idx_e idx, input logic [TICK_W-1:0] value);
    stim_t s;
    s.kind      = STIM_WRITE;
    s.mark      = '0;
    s.space     = '0;
    s.last      = 1'b0;
    s.reg_idx   = idx;
    s.wdata     = value;
    s.idle_pct  = cur_idle_pct;
    s.stall_pct = cur_stall_pct;
    tx_plan.push_back(s);
    planned_nom[idx] = value;
  endtask

  task automatic push_hold();
    stim_t s;
    s.kind      = STIM_HOLD;
    s.mark      = '0;
    s.space     = '0;
    s.last      = 1'b0;
    s.reg_idx   = necir_pkg::REG_LEADER_MARK;
    s.wdata     = '0;
    s.idle_pct  = cur_idle_pct;
    s.stall_pct = cur_stall_pct;
    tx_plan.push_back(s);
  endtask

  // A duration inside the window of nom, clamped to the field range.
  function automatic logic [TICK_W-1:0] ticks_near(input logic [TICK_W-1:0] nom);
    int lo;
    int hi;
    lo = int'(nom) - int'(necir_pkg::TOLERANCE) + 1;
    hi = int'(nom) + int'(necir_pkg::TOLERANCE) - 1;
    if (lo < 0) lo = 0;
    if (hi > int'(TICK_TOP)) hi = int'(TICK_TOP);
    return TICK_W'($urandom_range(hi, lo));
  endfunction

  // Any duration, weighted towards the field extremes.
  function automatic logic [TICK_W-1:0] ticks_any();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TICK_TOP;
      default: return TICK_W'($urandom_range(0, int'(TICK_TOP)));
    endcase
  endfunction

  // Leader, 16 address and 16 command bits LSB first, then stop and any overrun.
  // A length other than 34 gives a truncated or overlong frame; bad_pos garbles one symbol.
  task automatic push_data_frame(input logic [15:0] addr, input logic [15:0] cmd,
                                 input int bad_pos, input int len);
    logic [31:0]       payload;
    logic [TICK_W-1:0] mark;
    logic [TICK_W-1:0] space;
    payload = {cmd, addr};
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        mark  = ticks_near(planned_nom[necir_pkg::REG_LEADER_MARK]);
        space = ticks_near(planned_nom[necir_pkg::REG_LEADER_SPACE]);
      end else if (i <= 32 && payload[i-1]) begin
        mark  = ticks_near(planned_nom[necir_pkg::REG_ONE_MARK]);
        space = ticks_near(planned_nom[necir_pkg::REG_ONE_SPACE]);
      end else if (i <= 32) begin
        mark  = ticks_near(planned_nom[necir_pkg::REG_ZERO_MARK]);
        space = ticks_near(planned_nom[necir_pkg::REG_ZERO_SPACE]);
      end else begin
        mark  = ticks_near(planned_nom[necir_pkg::REG_ZERO_MARK]);
        space = ticks_any();
      end
      if (i == bad_pos) begin
        mark  = ticks_any();
        space = ticks_any();
      end
      push_symbol(mark, space, i == len - 1);
    end
  endtask

  task automatic push_repeat_frame(input int len);
    push_symbol(ticks_near(planned_nom[necir_pkg::REG_REPEAT_MARK]),
                ticks_near(planned_nom[necir_pkg::REG_REPEAT_SPACE]), len == 1);
    for (int i = 1; i < len; i++)
      push_symbol(ticks_near(planned_nom[necir_pkg::REG_ZERO_MARK]), ticks_any(), i == len - 1);
  endtask

  // Symbols half of which land near some programmed nominal.
  task automatic push_noise_frame(input int len);
    logic [TICK_W-1:0] mark;
    logic [TICK_W-1:0] space;
    for (int i = 0; i < len; i++) begin
      mark  = $urandom_range(0, 1)
              ? ticks_near(planned_nom[$urandom_range(0, necir_pkg::REG_NUM - 1)])
              : ticks_any();
      space = $urandom_range(0, 1)
              ? ticks_near(planned_nom[$urandom_range(0, necir_pkg::REG_NUM - 1)])
              : ticks_any();
      push_symbol(mark, space, i == len - 1);
    end
  endtask

  // Register settings per phase: all-zero and all-max extremes, nominals under the
  // tolerance, overlapping one/zero windows, random values, and the reset values.
  function automatic logic [TICK_W-1:0] phase_nominal(input int unsigned phase,
                                                      input int unsigned idx);
    case (phase)
      0: return '0;
      1: return TICK_TOP;
      2: return TICK_W'($urandom_range(0, int'(necir_pkg::TOLERANCE) - 1));
      3: begin
        if (idx == necir_pkg::REG_ONE_SPACE || idx == necir_pkg::REG_ZERO_SPACE)
          return TICK_W'(600);
        if (idx == necir_pkg::REG_ONE_MARK || idx == necir_pkg::REG_ZERO_MARK)
          return TICK_W'(560);
        return necir_pkg::CFG_RESET[idx];
      end
      PHASE_COUNT - 1: return necir_pkg::CFG_RESET[idx];
      default: return TICK_W'($urandom_range(0, int'(TICK_TOP)));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed frames at reset settings, then random phases.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_start;
    int unsigned pick;
    int          bad_pos;
    for (int i = 0; i < necir_pkg::REG_NUM; i++) planned_nom[i] = necir_pkg::CFG_RESET[i];

    // Repeat with no data frame before it: reports zero address and command.
    push_repeat_frame(2);
    push_data_frame(16'h00FF, 16'hFF00, NO_FAULT, 34);
    push_repeat_frame(2);
    // Repeat windows at their edges: 199 ticks off is inside, 200 is outside.
    push_symbol(TICK_W'(9199), TICK_W'(2449), 1'b0);
    push_symbol('0, '0, 1'b1);
    push_symbol(TICK_W'(8801), TICK_W'(2051), 1'b0);
    push_symbol('0, '0, 1'b1);
    push_symbol(TICK_W'(9200), TICK_W'(2250), 1'b0);
    push_symbol('0, '0, 1'b1);
    push_symbol(TICK_W'(9000), TICK_W'(2050), 1'b0);
    push_symbol('0, '0, 1'b1);
    // Field extremes as one-symbol frames.
    push_symbol('0, TICK_TOP, 1'b1);
    push_symbol(TICK_TOP, '0, 1'b1);

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      // Pause until every report is back, then reprogram all eight nominals.
      push_hold();
      cur_idle_pct  = (p == PHASE_COUNT - 1) ? 0 : $urandom_range(0, 2) * 25;
      cur_stall_pct = (p == PHASE_COUNT - 1) ? 0 : $urandom_range(0, 2) * 25;
      for (int unsigned i = 0; i < necir_pkg::REG_NUM; i++)
        push_write(necir_pkg::reg_idx_e'(i), phase_nominal(p, i));

      phase_start = symbols_planned;
      while (symbols_planned - phase_start < PHASE_SYMBOLS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          bad_pos = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 33) : NO_FAULT;
          push_data_frame(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                          bad_pos, 34);
        end else if (pick < 70) begin
          push_repeat_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 2);
        end else if (pick < 85) begin
          push_noise_frame($urandom_range(1, 4));
        end else if (pick < 93) begin
          push_data_frame(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                          NO_FAULT, $urandom_range(0, 1) ? 33 : 35);
        end else begin
          // overlong frame; the longest ones drive the count into saturation
          push_data_frame(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                          NO_FAULT, $urandom_range(36, 70));
        end
      end
    end

    // Wait for the plan to drain and every report to arrive, then let the pipe settle.
    while (tx_plan.size() != 0 || in_valid_i || cfg_valid_i || frames_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/necir_pkg.sv
sv/nec_ir_frame_decoder_top.sv
sim/tb_top.sv
